FILE: sv/cache_with_next_line_prefetch_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef CACHE_WITH_NEXT_LINE_PREFETCH_MACROS_SVH
`define CACHE_WITH_NEXT_LINE_PREFETCH_MACROS_SVH

// Implication checked on every rising clk edge outside reset.
`define CWNLP_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cache check failed");

// Condition that must hold on every rising clk edge outside reset.
`define CWNLP_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cache invariant failed");

`endif

FILE: sv/cwnlp_pkg.sv
// Package: types, constants and address helpers for the cache.
`default_nettype none
package cwnlp_pkg;
    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_BITS = 48;
    localparam int STAMP_W   = 32;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int WAYS_W    = WAY_W + 1;
    localparam int OFF_W     = 4;
    localparam int SIB_W     = 4;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int IN_W      = 56;
    localparam int OUT_W     = 8;

    // One memory row holds a whole set.
    typedef struct packed {
        logic [MAX_WAYS-1:0]                valid;
        logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag;
        logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic hit;
        logic adv;
    } lookup_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEM,
        ST_PF_RD,
        ST_PF
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFF  = 3'd0,
        CFG_SIB  = 3'd1,
        CFG_WAYS = 3'd2,
        CFG_LRU  = 3'd3,
        CFG_PF   = 3'd4
    } cfg_idx_t;

    function automatic logic [SIB_W-1:0] eff_sib(input logic [SIB_W-1:0] sib);
        return (sib > SIB_W'(SET_W)) ? SIB_W'(SET_W) : sib;
    endfunction

    function automatic logic [WAYS_W-1:0] eff_ways(input logic [CFG_W-1:0] w);
        logic [WAYS_W-1:0] r;
        if (w == '0)
            r = WAYS_W'(1);
        else if (w > CFG_W'(MAX_WAYS))
            r = WAYS_W'(MAX_WAYS);
        else
            r = WAYS_W'(w);
        return r;
    endfunction

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_BITS-1:0] addr,
                                                 input logic [OFF_W-1:0] off,
                                                 input logic [SIB_W-1:0] sib);
        logic [ADDR_BITS-1:0] s;
        logic [SET_W:0]       m;
        s = addr >> off;
        m = ((SET_W+1)'(1) << sib) - (SET_W+1)'(1);
        return s[SET_W-1:0] & m[SET_W-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] tag_of(input logic [ADDR_BITS-1:0] addr,
                                                    input logic [OFF_W-1:0] off,
                                                    input logic [SIB_W-1:0] sib);
        logic [OFF_W:0] sh;
        sh = {1'b0, off} + {1'b0, sib};
        return addr >> sh;
    endfunction
endpackage
`default_nettype wire

FILE: sv/cwnlp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cwnlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/cwnlp_lookup.sv
// Set lookup: hit detection, fill or victim choice, stamp update of one row.
`default_nettype none
module cwnlp_lookup (
    input  wire cwnlp_pkg::row_t                row,
    input  wire logic                           row_valid,
    input  wire logic [cwnlp_pkg::ADDR_BITS-1:0] tag,
    input  wire logic [cwnlp_pkg::WAYS_W-1:0]   ways,
    input  wire logic                           refresh,
    input  wire logic [cwnlp_pkg::STAMP_W-1:0]  cnt,
    output cwnlp_pkg::row_t                     new_row,
    output cwnlp_pkg::lookup_t                  res,
    output logic      [cwnlp_pkg::STAMP_W-1:0]  cnt_next
);
    import cwnlp_pkg::*;

    logic [MAX_WAYS-1:0] vld;
    logic                found;
    logic [WAY_W-1:0]    fidx;
    logic [WAY_W-1:0]    victim;
    logic [STAMP_W-1:0]  best;
    logic [STAMP_W-1:0]  cnt_inc;

    assign vld     = row_valid ? row.valid : '0;
    assign cnt_inc = (cnt == '1) ? cnt : cnt + STAMP_W'(1);

    // First way in use that is empty or matches
    always_comb
    begin
        found = 1'b0;
        fidx  = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!found && (WAYS_W'(w) < ways) && (!vld[w] || row.tag[w] == tag))
            begin
                found = 1'b1;
                fidx  = WAY_W'(w);
            end
        end
    end

    // Oldest stamp, highest way on a tie
    always_comb
    begin
        victim = '0;
        best   = row.stamp[0];
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if ((WAYS_W'(w) < ways) && (row.stamp[w] <= best))
            begin
                best   = row.stamp[w];
                victim = WAY_W'(w);
            end
        end
    end

    // Row update
    always_comb
    begin
        new_row       = row;
        new_row.valid = vld;
        res.hit       = found && vld[fidx];
        res.adv       = 1'b1;
        if (res.hit)
        begin
            res.adv = refresh;
            if (refresh)
                new_row.stamp[fidx] = cnt_inc;
        end
        else if (found)
        begin
            new_row.valid[fidx] = 1'b1;
            new_row.tag[fidx]   = tag;
            new_row.stamp[fidx] = cnt_inc;
        end
        else
        begin
            new_row.valid[victim] = 1'b1;
            new_row.tag[victim]   = tag;
            new_row.stamp[victim] = cnt_inc;
        end
        cnt_next = res.adv ? cnt_inc : cnt;
    end
endmodule
`default_nettype wire

FILE: sv/cache_with_next_line_prefetch.sv
// Top level: tag-only write-through cache with next-line prefetch.
//
// s_axis carries one access request: address and a write flag. m_axis
// returns one result per request: hit, memory reads (0..2), memory write.
// cfg_we/cfg_index/cfg_data write the five configuration registers; write
// them only while the block is idle.
// All sets live in one RAM, one row per set (tags, stamps, valid bits of
// every way), with registered read data. A request is a set read, then a
// check and write-back of the row. A demand miss with prefetch on adds a
// next-line read and its check and write; requests are taken only in idle.
// The result goes to an output register, so a new request is taken while a
// result waits. If the receiver stalls and a second result is ready, the
// block holds its final row update until the register drains; the demand
// row of a prefetching miss is written without waiting.
// Reset clears the per-set valid flags and the stamp counter at once; no
// clearing pass is run. Configuration returns to its reset values.
`default_nettype none
`include "cache_with_next_line_prefetch_macros.svh"
module cache_with_next_line_prefetch (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [47:0] address, [48] is_write, [55:49] zero
    input  wire logic [cwnlp_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] hit, [2:1] memory_reads, [3] memory_write, [7:4] zero
    output logic      [cwnlp_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [cwnlp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cwnlp_pkg::CFG_W-1:0]     cfg_data
);
    import cwnlp_pkg::*;

    state_t                 state_reg, state_next;
    logic [OFF_W-1:0]       off_reg;
    logic [SIB_W-1:0]       sib_reg;
    logic [CFG_W-1:0]       ways_reg;
    logic                   lru_reg;
    logic                   pf_reg;
    logic [STAMP_W-1:0]     cnt_reg;
    logic [MAX_SETS-1:0]    rowv_reg;
    logic                   rv_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [SET_W-1:0]       set_reg;
    logic                   wr_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [1:0]             out_reads_reg;
    logic                   out_wr_reg;

    logic [SIB_W-1:0]       sib_e;
    logic [WAYS_W-1:0]      ways_e;
    logic                   in_acc;
    logic                   out_free;
    logic                   ram_re, ram_we, out_load, cnt_load, next_load;
    logic [SET_W-1:0]       ram_raddr;
    logic                   load_hit;
    logic [1:0]             load_reads;
    logic [ROW_W-1:0]       ram_rdata;
    row_t                   new_row;
    lookup_t                lk;
    logic [STAMP_W-1:0]     cnt_next;
    logic [ADDR_BITS-1:0]   in_addr;

    assign sib_e    = eff_sib(sib_reg);
    assign ways_e   = eff_ways(ways_reg);
    assign in_addr  = s_axis_tdata[ADDR_BITS-1:0];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Set memory
    cwnlp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (new_row),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row check and update
    cwnlp_lookup u_lookup (
        .row       (row_t'(ram_rdata)),
        .row_valid (rv_reg),
        .tag       (tag_of(addr_reg, off_reg, sib_e)),
        .ways      (ways_e),
        .refresh   ((state_reg == ST_DEM) && lru_reg),
        .cnt       (cnt_reg),
        .new_row   (new_row),
        .res       (lk),
        .cnt_next  (cnt_next)
    );

    // Sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        ram_re     = 1'b0;
        ram_raddr  = set_of(addr_reg, off_reg, sib_e);
        ram_we     = 1'b0;
        out_load   = 1'b0;
        cnt_load   = 1'b0;
        next_load  = 1'b0;
        load_hit   = 1'b0;
        load_reads = 2'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = set_of(in_addr, off_reg, sib_e);
                if (in_acc)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_DEM;
                end
            end
            ST_DEM:
            begin
                if (!lk.hit && pf_reg)
                begin
                    ram_we     = 1'b1;
                    cnt_load   = 1'b1;
                    next_load  = 1'b1;
                    state_next = ST_PF_RD;
                end
                else if (out_free)
                begin
                    ram_we     = 1'b1;
                    cnt_load   = 1'b1;
                    out_load   = 1'b1;
                    load_hit   = lk.hit;
                    load_reads = lk.hit ? 2'd0 : 2'd1;
                    state_next = ST_IDLE;
                end
            end
            ST_PF_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_PF;
            end
            ST_PF:
            begin
                if (out_free)
                begin
                    ram_we     = !lk.hit;
                    cnt_load   = 1'b1;
                    out_load   = 1'b1;
                    load_reads = lk.hit ? 2'd1 : 2'd2;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rowv_reg      <= '0;
            out_valid_reg <= 1'b0;
            off_reg       <= OFF_W'(6);
            sib_reg       <= '0;
            ways_reg      <= CFG_W'(1);
            lru_reg       <= 1'b0;
            pf_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_load)
                cnt_reg <= cnt_next;
            if (ram_we)
                rowv_reg[set_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_OFF:  off_reg  <= cfg_data;
                    CFG_SIB:  sib_reg  <= cfg_data;
                    CFG_WAYS: ways_reg <= cfg_data;
                    CFG_LRU:  lru_reg  <= cfg_data[0];
                    CFG_PF:   pf_reg   <= cfg_data[0];
                    default:  ;
                endcase
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            addr_reg <= in_addr;
            wr_reg   <= s_axis_tdata[ADDR_BITS];
        end
        else if (next_load)
        begin
            addr_reg <= addr_reg + (ADDR_BITS'(1) << off_reg);
        end
        if (ram_re)
        begin
            set_reg <= ram_raddr;
            rv_reg  <= rowv_reg[ram_raddr];
        end
        if (out_load)
        begin
            out_hit_reg   <= load_hit;
            out_reads_reg <= load_reads;
            out_wr_reg    <= wr_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_wr_reg, out_reads_reg, out_hit_reg};

    // Checks
    `CWNLP_ASSERT_IMPL(a_we_state, ram_we, (state_reg == ST_DEM) || (state_reg == ST_PF))
    `CWNLP_ASSERT_IMPL(a_load_free, out_load, !out_valid_reg || m_axis_tready)
    `CWNLP_ASSERT_IMPL(a_cnt_mono, 1'b1, cnt_reg >= $past(cnt_reg))
endmodule
`default_nettype wire
